// File: src/swec_pkg.sv
// ----------------------------------------------------------------------------
// swec_pkg
// Types and constants shared by the sliding window event counter.
// ----------------------------------------------------------------------------
package swec_pkg;

	localparam int WIN_W  = 25;
	localparam int THR_W  = 6;
	localparam int TIME_W = 32;
	localparam int EST_W  = 25;

	localparam logic [WIN_W-1:0]  WIN_RESET  = 25'd1024;
	localparam logic [THR_W-1:0]  THR_RESET  = 6'd7;
	localparam logic [TIME_W-1:0] TIME_RESET = 32'd1;
	localparam logic [EST_W-1:0]  EST_CAP    = 25'd16777216;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	localparam logic REG_WINDOW    = 1'b0;
	localparam logic REG_THRESHOLD = 1'b1;

	typedef struct packed {
		logic              operation;
		logic [TIME_W-1:0] event_time;
		logic [WIN_W-1:0]  query_span;
	} cmd_t;

	typedef struct packed {
		logic             is_answer;
		logic [EST_W-1:0] estimate;
		logic             overflow;
	} result_t;

	typedef struct packed {
		logic [WIN_W-1:0] window_size;
		logic [THR_W-1:0] merge_threshold;
	} cfg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXP,
		S_EXP_CMP,
		S_PUSH,
		S_MERGE,
		S_MERGE_CMP,
		S_MERGE_PUSH,
		S_QLVL,
		S_QLVL_CMP,
		S_QBND,
		S_QBND_CMP
	} state_t;

endpackage

// File: src/sliding_window_event_counter.sv
// ----------------------------------------------------------------------------
// sliding_window_event_counter
// Exponential histogram estimate of the event count in a recent time span.
// ----------------------------------------------------------------------------
// An item is taken on start while busy is low. An insert item (operation 0)
// makes event_time the current time, expires old buckets from the top level,
// pushes a new bucket and runs the merge cascade. A query item (operation 1)
// estimates the events within query_span of the current time.
// Each item gives exactly one result, shown for one cycle with done high;
// the receiver cannot stall, so results never wait.
// An insert expires the oldest top-level bucket while its age is at least
// the window, dropping empty top levels, then pushes a bucket at level 0;
// each level holding threshold buckets or more gives up its two oldest as
// one bucket on the next level, or sets overflow at the top level. A query
// adds every whole level in span, then half a bucket of the first level
// whose oldest bucket is out of span, plus one bucket for each of its
// newest buckets still within span.
// busy stays high while the item is worked on. Reset leaves the histogram empty,
// current time one, window 1024 and merge threshold 7; the stamp RAM needs
// no clearing pass. Registers: window_size at 0x0, merge_threshold at 0x4.
// ----------------------------------------------------------------------------
module sliding_window_event_counter #(
	parameter int MAX_LEVELS        = 24,
	parameter int BUCKETS_PER_LEVEL = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  swec_pkg::cmd_t    cmd,
	output logic              done,
	output swec_pkg::result_t result
);

	swec_pkg::cfg_t cfg;

	swec_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	swec_core #(
		.MAX_LEVELS        (MAX_LEVELS),
		.BUCKETS_PER_LEVEL (BUCKETS_PER_LEVEL)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result shown on two cycles");

	a_insert_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.is_answer |-> result.estimate == '0)
		else $error("insert result carries an estimate");

	a_ovf_insert: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.overflow |-> !result.is_answer)
		else $error("overflow flagged on a query");

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.estimate <= swec_pkg::EST_CAP)
		else $error("estimate above saturation cap");

endmodule

// File: src/swec_ram.sv
// ----------------------------------------------------------------------------
// swec_ram
// Generic single write, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module swec_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/swec_apb.sv
// ----------------------------------------------------------------------------
// swec_apb
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module swec_apb (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output swec_pkg::cfg_t     cfg
);

	logic [swec_pkg::WIN_W-1:0] window_q;
	logic [swec_pkg::THR_W-1:0] thr_q;
	logic                       wr_en;

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= swec_pkg::WIN_RESET;
			thr_q    <= swec_pkg::THR_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				swec_pkg::REG_WINDOW:    window_q <= pwdata[swec_pkg::WIN_W-1:0];
				swec_pkg::REG_THRESHOLD: thr_q    <= pwdata[swec_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			swec_pkg::REG_WINDOW:    prdata = {{(32-swec_pkg::WIN_W){1'b0}}, window_q};
			swec_pkg::REG_THRESHOLD: prdata = {{(32-swec_pkg::THR_W){1'b0}}, thr_q};
			default:                 prdata = '0;
		endcase
	end

	assign cfg.window_size     = window_q;
	assign cfg.merge_threshold = thr_q;

endmodule

// File: src/swec_core.sv
// ----------------------------------------------------------------------------
// swec_core
// Level sequencer with one shared age subtractor and saturating adds over the
// bucket stamp RAM.
// ----------------------------------------------------------------------------
module swec_core #(
	parameter int MAX_LEVELS        = 24,
	parameter int BUCKETS_PER_LEVEL = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  swec_pkg::cfg_t    cfg,
	input  logic              start,
	output logic              busy,
	input  swec_pkg::cmd_t    cmd,
	output logic              done,
	output swec_pkg::result_t result
);

	localparam int LW  = $clog2(MAX_LEVELS + 1);
	localparam int LIW = $clog2(MAX_LEVELS);
	localparam int CW  = $clog2(BUCKETS_PER_LEVEL + 1);
	localparam int HW  = $clog2(BUCKETS_PER_LEVEL);
	localparam int RAW = $clog2(MAX_LEVELS * BUCKETS_PER_LEVEL);
	localparam int TW  = (CW > swec_pkg::THR_W) ? CW : swec_pkg::THR_W;
	localparam int SW  = ((CW + MAX_LEVELS > swec_pkg::EST_W) ? CW + MAX_LEVELS
		: swec_pkg::EST_W) + 1;

	swec_pkg::state_t state_q, state_nxt;

	logic [LW-1:0]                 lvl_q, liu_q;
	logic [CW-1:0]                 j_q;
	logic [swec_pkg::EST_W-1:0]    sum_q;
	logic [swec_pkg::TIME_W-1:0]   ct_q, older_q;
	logic [swec_pkg::WIN_W-1:0]    span_q;
	logic                          ovf_q;
	logic [CW-1:0]                 cnt_q  [MAX_LEVELS];
	logic [HW-1:0]                 head_q [MAX_LEVELS];
	logic                          done_q;
	swec_pkg::result_t             result_q;

	logic [LW-1:0]                 sel_lvl;
	logic [LIW-1:0]                sel_idx;
	logic [CW-1:0]                 sel_cnt;
	logic [HW-1:0]                 sel_head;
	logic [CW-1:0]                 mem_off;
	logic                          mem_re, mem_we;
	logic [swec_pkg::TIME_W-1:0]   mem_wdata, mem_rdata;
	logic [RAW-1:0]                mem_addr;
	logic [swec_pkg::TIME_W-1:0]   age;
	logic [TW-1:0]                 thr_eff;
	logic                          merge_go;
	logic                          cnt_room;
	logic [SW-1:0]                 add_cnt, add_half, add_one;

	function automatic logic [HW-1:0] ring(input logic [HW-1:0] head,
		input logic [CW-1:0] off);
		logic [CW:0] s;
		s = (CW+1)'(head) + (CW+1)'(off);
		if (s >= (CW+1)'(BUCKETS_PER_LEVEL)) begin
			s = s - (CW+1)'(BUCKETS_PER_LEVEL);
		end
		return HW'(s);
	endfunction

	function automatic logic [swec_pkg::EST_W-1:0] sat_add(
		input logic [swec_pkg::EST_W-1:0] a, input logic [SW-1:0] b);
		logic [SW-1:0] s;
		s = SW'(a) + b;
		if (s > SW'(swec_pkg::EST_CAP)) begin
			return swec_pkg::EST_CAP;
		end
		return s[swec_pkg::EST_W-1:0];
	endfunction

	// level under access
	always_comb begin
		unique case (state_q)
			swec_pkg::S_EXP, swec_pkg::S_EXP_CMP: sel_lvl = liu_q - LW'(1);
			swec_pkg::S_MERGE_PUSH:               sel_lvl = lvl_q + LW'(1);
			default:                              sel_lvl = lvl_q;
		endcase
	end

	assign sel_idx  = sel_lvl[LIW-1:0];
	assign sel_cnt  = cnt_q[sel_idx];
	assign sel_head = head_q[sel_idx];
	assign cnt_room = sel_cnt < CW'(BUCKETS_PER_LEVEL);

	always_comb begin
		thr_eff = TW'(cfg.merge_threshold);
		if (thr_eff < TW'(2)) begin
			thr_eff = TW'(2);
		end else if (thr_eff > TW'(BUCKETS_PER_LEVEL)) begin
			thr_eff = TW'(BUCKETS_PER_LEVEL);
		end
	end

	assign merge_go = (lvl_q < LW'(MAX_LEVELS)) && (TW'(sel_cnt) >= thr_eff);

	assign mem_addr = RAW'(sel_idx) * RAW'(BUCKETS_PER_LEVEL) + RAW'(ring(sel_head, mem_off));
	assign age      = ct_q - mem_rdata;

	assign add_cnt  = SW'(sel_cnt) << lvl_q;
	assign add_one  = SW'(1) << lvl_q;
	assign add_half = (lvl_q == '0) ? '0 : (SW'(1) << (lvl_q - LW'(1)));

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			swec_pkg::S_IDLE: begin
				if (start) begin
					state_nxt = (cmd.operation == swec_pkg::OP_QUERY) ?
						swec_pkg::S_QLVL : swec_pkg::S_EXP;
				end
			end
			swec_pkg::S_EXP: begin
				if (liu_q == '0) begin
					state_nxt = swec_pkg::S_PUSH;
				end else if (sel_cnt != '0) begin
					state_nxt = swec_pkg::S_EXP_CMP;
				end
			end
			swec_pkg::S_EXP_CMP: begin
				state_nxt = (age >= swec_pkg::TIME_W'(cfg.window_size)) ?
					swec_pkg::S_EXP : swec_pkg::S_PUSH;
			end
			swec_pkg::S_PUSH: state_nxt = swec_pkg::S_MERGE;
			swec_pkg::S_MERGE: begin
				state_nxt = merge_go ? swec_pkg::S_MERGE_CMP : swec_pkg::S_IDLE;
			end
			swec_pkg::S_MERGE_CMP: begin
				state_nxt = (lvl_q + LW'(1) < LW'(MAX_LEVELS)) ?
					swec_pkg::S_MERGE_PUSH : swec_pkg::S_MERGE;
			end
			swec_pkg::S_MERGE_PUSH: state_nxt = swec_pkg::S_MERGE;
			swec_pkg::S_QLVL: begin
				if (lvl_q < liu_q) begin
					state_nxt = (sel_cnt == '0) ? swec_pkg::S_QLVL : swec_pkg::S_QLVL_CMP;
				end else begin
					state_nxt = swec_pkg::S_IDLE;
				end
			end
			swec_pkg::S_QLVL_CMP: begin
				state_nxt = (age < swec_pkg::TIME_W'(span_q)) ?
					swec_pkg::S_QLVL : swec_pkg::S_QBND;
			end
			swec_pkg::S_QBND: begin
				state_nxt = (j_q != '0) ? swec_pkg::S_QBND_CMP : swec_pkg::S_IDLE;
			end
			swec_pkg::S_QBND_CMP: begin
				state_nxt = (age <= swec_pkg::TIME_W'(span_q)) ?
					swec_pkg::S_QBND : swec_pkg::S_IDLE;
			end
			default: state_nxt = swec_pkg::S_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_off   = '0;
		mem_wdata = ct_q;
		unique case (state_q)
			swec_pkg::S_EXP:   mem_re = (liu_q != '0) && (sel_cnt != '0);
			swec_pkg::S_MERGE: mem_re = merge_go;
			swec_pkg::S_QLVL:  mem_re = (lvl_q < liu_q) && (sel_cnt != '0);
			swec_pkg::S_QBND: begin
				mem_re  = j_q != '0;
				mem_off = j_q - CW'(1);
			end
			swec_pkg::S_PUSH: begin
				mem_we  = cnt_room;
				mem_off = sel_cnt;
			end
			swec_pkg::S_MERGE_PUSH: begin
				mem_we    = cnt_room;
				mem_off   = sel_cnt;
				mem_wdata = older_q;
			end
			default: ;
		endcase
	end

	swec_ram #(
		.WIDTH(swec_pkg::TIME_W),
		.DEPTH(MAX_LEVELS * BUCKETS_PER_LEVEL)
	) u_stamps (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_addr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_addr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= swec_pkg::S_IDLE;
			lvl_q    <= '0;
			liu_q    <= '0;
			j_q      <= '0;
			sum_q    <= '0;
			ct_q     <= swec_pkg::TIME_RESET;
			older_q  <= '0;
			span_q   <= '0;
			ovf_q    <= 1'b0;
			done_q   <= 1'b0;
			result_q <= '0;
			for (int i = 0; i < MAX_LEVELS; i++) begin
				cnt_q[i]  <= '0;
				head_q[i] <= '0;
			end
		end else begin
			state_q <= state_nxt;
			done_q  <= 1'b0;
			unique case (state_q)
				swec_pkg::S_IDLE: begin
					if (start) begin
						lvl_q  <= '0;
						sum_q  <= '0;
						ovf_q  <= 1'b0;
						span_q <= cmd.query_span;
						if (cmd.operation == swec_pkg::OP_INSERT) begin
							ct_q <= cmd.event_time;
						end
					end
				end
				swec_pkg::S_EXP: begin
					if (liu_q != '0 && sel_cnt == '0) begin
						liu_q <= liu_q - LW'(1);
					end
				end
				swec_pkg::S_EXP_CMP: begin
					if (age >= swec_pkg::TIME_W'(cfg.window_size)) begin
						cnt_q[sel_idx]  <= sel_cnt - CW'(1);
						head_q[sel_idx] <= ring(sel_head, CW'(1));
					end
				end
				swec_pkg::S_PUSH: begin
					if (liu_q == '0) begin
						liu_q <= LW'(1);
					end
					if (cnt_room) begin
						cnt_q[sel_idx] <= sel_cnt + CW'(1);
					end
				end
				swec_pkg::S_MERGE: begin
					if (!merge_go) begin
						done_q   <= 1'b1;
						result_q <= '{is_answer: 1'b0, estimate: '0, overflow: ovf_q};
					end
				end
				swec_pkg::S_MERGE_CMP: begin
					older_q         <= mem_rdata;
					cnt_q[sel_idx]  <= sel_cnt - CW'(2);
					head_q[sel_idx] <= ring(sel_head, CW'(2));
					if (lvl_q + LW'(1) >= LW'(MAX_LEVELS)) begin
						ovf_q <= 1'b1;
						lvl_q <= lvl_q + LW'(1);
					end
				end
				swec_pkg::S_MERGE_PUSH: begin
					if (cnt_room) begin
						cnt_q[sel_idx] <= sel_cnt + CW'(1);
					end
					if (liu_q < lvl_q + LW'(2)) begin
						liu_q <= lvl_q + LW'(2);
					end
					lvl_q <= lvl_q + LW'(1);
				end
				swec_pkg::S_QLVL: begin
					if (lvl_q < liu_q) begin
						if (sel_cnt == '0) begin
							lvl_q <= lvl_q + LW'(1);
						end
					end else begin
						done_q   <= 1'b1;
						result_q <= '{is_answer: 1'b1, estimate: sum_q, overflow: 1'b0};
					end
				end
				swec_pkg::S_QLVL_CMP: begin
					if (age < swec_pkg::TIME_W'(span_q)) begin
						sum_q <= sat_add(sum_q, add_cnt);
						lvl_q <= lvl_q + LW'(1);
					end else begin
						sum_q <= sat_add(sum_q, add_half);
						j_q   <= sel_cnt;
					end
				end
				swec_pkg::S_QBND: begin
					if (j_q == '0) begin
						done_q   <= 1'b1;
						result_q <= '{is_answer: 1'b1, estimate: sum_q, overflow: 1'b0};
					end
				end
				swec_pkg::S_QBND_CMP: begin
					if (age <= swec_pkg::TIME_W'(span_q)) begin
						sum_q <= sat_add(sum_q, add_one);
						j_q   <= j_q - CW'(1);
					end else begin
						done_q   <= 1'b1;
						result_q <= '{is_answer: 1'b1, estimate: sum_q, overflow: 1'b0};
					end
				end
				default: ;
			endcase
		end
	end

	assign busy   = state_q != swec_pkg::S_IDLE;
	assign done   = done_q;
	assign result = result_q;

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sliding window event counter.
// Inserts and queries are driven with random gaps through start/busy, an
// in-bench exponential histogram predicts every result, and a scoreboard
// compares each done strobe with the oldest prediction. Window size and
// merge threshold are written over APB between phases, including extremes.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int LEVELS  = 24;
	localparam int PER_LVL = 32;
	localparam int WDOG    = 200000;

	class est_scoreboard;
		swec_pkg::result_t pending[$];
		int                errors;

		function void note_cmd(swec_pkg::result_t r);
			pending = {pending, r};
		endfunction

		function void check_result(swec_pkg::result_t r);
			swec_pkg::result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result %p", r);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (e.is_answer !== r.is_answer) begin
				$error("is_answer expected %0d actual %0d", e.is_answer, r.is_answer);
				errors++;
			end
			if (e.estimate !== r.estimate) begin
				$error("estimate expected %0d actual %0d", e.estimate, r.estimate);
				errors++;
			end
			if (e.overflow !== r.overflow) begin
				$error("overflow expected %0d actual %0d", e.overflow, r.overflow);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 0;
	logic              arst_n = 0;
	logic              psel = 0, penable = 0, pwrite = 0;
	logic [2:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              start = 0;
	logic              busy;
	swec_pkg::cmd_t    cmd = '0;
	logic              done;
	swec_pkg::result_t result;

	est_scoreboard sb = new();

	logic [swec_pkg::TIME_W-1:0] stamps [LEVELS][PER_LVL];
	int                          lvl_cnt [LEVELS];
	int                          lvls_used;
	logic [swec_pkg::TIME_W-1:0] now_time;
	logic [swec_pkg::WIN_W-1:0]  win;
	logic [swec_pkg::THR_W-1:0]  thr;
	logic [swec_pkg::TIME_W-1:0] tcur;
	int                          idle_cycles = 0;
	bit                          quiet;

	sliding_window_event_counter u_top (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .cmd(cmd), .done(done), .result(result)
	);

	always #1 clk = ~clk;

	function automatic void pop_oldest(int l, int n);
		if (n > lvl_cnt[l])
			n = lvl_cnt[l];
		for (int i = 0; i + n < lvl_cnt[l]; i++)
			stamps[l][i] = stamps[l][i+n];
		lvl_cnt[l] -= n;
	endfunction

	function automatic void push_stamp(int l, logic [swec_pkg::TIME_W-1:0] s);
		if (lvl_cnt[l] < PER_LVL) begin
			stamps[l][lvl_cnt[l]] = s;
			lvl_cnt[l]++;
		end
	endfunction

	function automatic swec_pkg::result_t predict_count(swec_pkg::cmd_t c);
		swec_pkg::result_t r;
		int t, l, j;
		logic [swec_pkg::TIME_W-1:0] older;
		longint sum;
		r = '0;
		if (c.operation == swec_pkg::OP_INSERT) begin
			t = (thr < 2) ? 2 : (thr > PER_LVL) ? PER_LVL : thr;
			now_time = c.event_time;
			forever begin
				while (lvls_used > 0 && lvl_cnt[lvls_used-1] == 0)
					lvls_used--;
				if (lvls_used == 0)
					break;
				if (swec_pkg::TIME_W'(now_time - stamps[lvls_used-1][0]) >= win)
					pop_oldest(lvls_used - 1, 1);
				else
					break;
			end
			if (lvls_used == 0)
				lvls_used = 1;
			push_stamp(0, now_time);
			l = 0;
			while (l < LEVELS && lvl_cnt[l] >= t) begin
				older = stamps[l][0];
				pop_oldest(l, 2);
				if (l + 1 < LEVELS) begin
					push_stamp(l + 1, older);
					if (lvls_used < l + 2)
						lvls_used = l + 2;
				end else begin
					r.overflow = 1'b1;
				end
				l++;
			end
		end else begin
			r.is_answer = 1'b1;
			sum = 0;
			l = 0;
			while (l < lvls_used && l < LEVELS) begin
				if (lvl_cnt[l] == 0 ||
					swec_pkg::TIME_W'(now_time - stamps[l][0]) < c.query_span) begin
					sum += longint'(lvl_cnt[l]) << l;
					l++;
					continue;
				end
				sum += (longint'(1) << l) >> 1;
				j = lvl_cnt[l];
				while (j > 0 &&
					swec_pkg::TIME_W'(now_time - stamps[l][j-1]) <= c.query_span) begin
					sum += longint'(1) << l;
					j--;
				end
				break;
			end
			r.estimate = (sum > swec_pkg::EST_CAP) ? swec_pkg::EST_CAP
				: swec_pkg::EST_W'(sum);
		end
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic apb_write(logic idx, logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == swec_pkg::REG_WINDOW)
			win = val[swec_pkg::WIN_W-1:0];
		else
			thr = val[swec_pkg::THR_W-1:0];
		@(posedge clk);
	endtask

	task automatic send_cmd(swec_pkg::cmd_t c);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_cmd(predict_count(c));
	endtask

	task automatic settle();
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic do_insert(logic [swec_pkg::TIME_W-1:0] t);
		swec_pkg::cmd_t c;
		c = '0;
		c.operation = swec_pkg::OP_INSERT;
		c.event_time = t;
		c.query_span = swec_pkg::WIN_W'($urandom);
		send_cmd(c);
	endtask

	task automatic do_query(logic [swec_pkg::WIN_W-1:0] s);
		swec_pkg::cmd_t c;
		c.operation = swec_pkg::OP_QUERY;
		c.event_time = $urandom;
		c.query_span = s;
		send_cmd(c);
	endtask

	task automatic random_phase(int n, int step_max);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 3))
					0: do_query(swec_pkg::WIN_W'($urandom_range(1, 64)));
					1: do_query(swec_pkg::WIN_W'($urandom_range(1, 1 << 24)));
					2: do_query(swec_pkg::WIN_W'(1 << 24));
					default: do_query(swec_pkg::WIN_W'($urandom));
				endcase
			end else begin
				if ($urandom_range(0, 19) == 0)
					tcur = $urandom;
				else
					tcur += $urandom_range(0, step_max);
				do_insert(tcur);
			end
		end
	endtask

	initial begin
		for (int l = 0; l < LEVELS; l++)
			lvl_cnt[l] = 0;
		lvls_used = 0;
		now_time = swec_pkg::TIME_RESET;
		win = swec_pkg::WIN_RESET;
		thr = swec_pkg::THR_RESET;
		quiet = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty histogram, span extremes, time extremes, wrap
		do_query(swec_pkg::WIN_W'(1));
		do_query(swec_pkg::WIN_W'(1 << 24));
		do_query('1);
		do_insert('0);
		do_insert('1);
		do_insert(32'd5);
		do_query(swec_pkg::WIN_W'(1));
		do_query(swec_pkg::WIN_W'(0));
		for (int i = 0; i < 12; i++)
			do_insert(32'd10 + i);
		do_query(swec_pkg::WIN_W'(3));
		do_query(swec_pkg::WIN_W'(1 << 24));
		do_insert(32'hFFFF_0000);
		do_query(swec_pkg::WIN_W'(1));
		settle();

		// minimum threshold with a wide window drives the merge cascade, then window one
		apb_write(swec_pkg::REG_THRESHOLD, 32'd2);
		apb_write(swec_pkg::REG_WINDOW, 32'd1 << 24);
		tcur = 0;
		for (int i = 0; i < 30; i++)
			do_insert(tcur);
		do_query(swec_pkg::WIN_W'(1 << 24));
		settle();
		apb_write(swec_pkg::REG_WINDOW, 32'd1);
		random_phase(40, 3);
		settle();

		// out-of-range thresholds clamp
		apb_write(swec_pkg::REG_THRESHOLD, 32'd0);
		apb_write(swec_pkg::REG_WINDOW, 32'hFFFF_FFFF);
		random_phase(60, 2);
		settle();
		apb_write(swec_pkg::REG_THRESHOLD, 32'd63);
		random_phase(60, 4);
		settle();
		apb_write(swec_pkg::REG_THRESHOLD, 32'd32);
		apb_write(swec_pkg::REG_WINDOW, 32'd50);
		random_phase(60, 5);
		settle();
		apb_write(swec_pkg::REG_THRESHOLD, 32'd3);
		apb_write(swec_pkg::REG_WINDOW, 32'd1 << 24);
		random_phase(70, 1 << 20);
		settle();
		apb_write(swec_pkg::REG_THRESHOLD, 32'd7);
		apb_write(swec_pkg::REG_WINDOW, 32'd1024);
		random_phase(80, 40);
		settle();

		quiet = 1;
		apb_write(swec_pkg::REG_THRESHOLD, 32'd4);
		apb_write(swec_pkg::REG_WINDOW, 32'd200);
		random_phase(60, 10);
		settle();

		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: filelist.f
src/swec_pkg.sv
src/swec_ram.sv
src/swec_apb.sv
src/swec_core.sv
src/sliding_window_event_counter.sv
sim/tb_top.sv
